// ===== design/minutes_to_calendar_date_core_assert.svh =====
// Assertion macros for the minute count to calendar date core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MINUTES_TO_CALENDAR_DATE_CORE_ASSERT_SVH
`define MINUTES_TO_CALENDAR_DATE_CORE_ASSERT_SVH

`ifndef SYNTH
// check a property while out of reset
`define MCD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mcd assertion failed");
// check a property on every edge, reset included
`define MCD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mcd assertion failed during or after reset");
`else
`define MCD_ASSERT(lbl, clk, rst_n, prop)
`define MCD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== design/mcd_pkg.sv =====
// Shared types, reciprocal constants and month tables for the date core.
// No dependencies.
package mcd_pkg;

    // field widths
    localparam int TOT_W   = 31;
    localparam int HRS_W   = 26;
    localparam int DAYS_W  = 21;
    localparam int YEAR_W  = 12;
    localparam int MON_W   = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int DOY_W   = 12;   // signed day of year during the year search
    localparam int TDATA_W = 32;

    typedef logic [YEAR_W-1:0]        t_year;
    typedef logic [MON_W-1:0]         t_mon;
    typedef logic [DAY_W-1:0]         t_day;
    typedef logic [HOUR_W-1:0]        t_hour;
    typedef logic [MIN_W-1:0]         t_min;
    typedef logic signed [DOY_W-1:0]  t_doy;

    // reciprocal multipliers: q = (x * M) >> SH, exact over the input range
    localparam logic [31:0] M_DIV60   = 32'd2290649225;  // 2^37 / 60, rounded up
    localparam int          SH_DIV60  = 37;
    localparam logic [23:0] M_DIV3    = 24'd11184811;    // 2^25 / 3, rounded up
    localparam int          SH_DIV3   = 25;
    localparam logic [21:0] M_DIV365  = 22'd2941759;     // 2^30 / 365, rounded up
    localparam int          SH_DIV365 = 30;
    localparam logic [12:0] M_DIV100  = 13'd5243;        // 2^19 / 100, rounded up
    localparam int          SH_DIV100 = 19;
    localparam logic [13:0] M_DIV1000 = 14'd8389;        // 2^23 / 1000, rounded up
    localparam int          SH_DIV1000 = 23;

    // last day of year of month idx (0 = January)
    function automatic logic [8:0] f_cum_end(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd31;
            4'd1:    base = 9'd59;
            4'd2:    base = 9'd90;
            4'd3:    base = 9'd120;
            4'd4:    base = 9'd151;
            4'd5:    base = 9'd181;
            4'd6:    base = 9'd212;
            4'd7:    base = 9'd243;
            4'd8:    base = 9'd273;
            4'd9:    base = 9'd304;
            4'd10:   base = 9'd334;
            default: base = 9'd365;
        endcase
        if (idx != 4'd0) begin
            base = base + 9'(leap);
        end
        return base;
    endfunction

    // days of the year before month idx
    function automatic logic [8:0] f_cum_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            default: base = 9'd334;
        endcase
        if (idx >= 4'd2) begin
            base = base + 9'(leap);
        end
        return base;
    endfunction

endpackage

// ===== design/minutes_to_calendar_date_core.sv =====
// Minute count to calendar date converter, thirteen-stage pipeline.
// Depends on mcd_pkg and minutes_to_calendar_date_core_assert.svh.
//
// channel | direction | word fields (lowest bit first)
// s_axis  | in        | minutes_total[30:0], pad[31]
// m_axis  | out       | year[11:0] month[15:12] day[20:16] hour[25:21] minute[31:26]
//
// One word per cycle sustained while the output is not stalled by back-pressure.
// Each divide by 60, 24 and 365 is a reciprocal multiply with a register after it.
// The year search takes three fixed step stages (at most three years back).
// Stages collapse bubbles: a stage loads whenever it is empty or the next one moves.
// Synchronous active-low reset empties every stage; payload is not reset.
`include "minutes_to_calendar_date_core_assert.svh"

module minutes_to_calendar_date_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [mcd_pkg::TDATA_W-1:0] i_s_axis_tdata,  // minutes_total, pad bit
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [mcd_pkg::TDATA_W-1:0] o_m_axis_tdata   // year, month, day, hour, minute
);
    import mcd_pkg::*;

    localparam int NST = 13;

    // stage valids and load enables
    logic [NST-1:0] r_vld;
    logic [NST-1:0] en;

    // stage payloads
    logic [62:0]        r_p0;
    logic [TOT_W-1:0]   r_t0;
    logic [HRS_W-1:0]   r_hours1;
    logic [46:0]        r_p2;
    logic [HRS_W-1:0]   r_hours2;
    logic [DAYS_W-1:0]  r_days3;
    logic [42:0]        r_p4;
    logic [DAYS_W-1:0]  r_days4;
    t_year              r_y5;
    logic [8:0]         r_r5;
    t_year              r_y6;
    logic [8:0]         r_r6;
    logic [24:0]        r_p100;
    logic [25:0]        r_p1000;
    t_min               r_mn [1:NST-1];
    t_hour              r_hr [3:NST-1];

    // year search stages 7..10
    t_year              r_sy    [0:3];
    t_doy               r_sdoy  [0:3];
    logic [3:0]         r_slk   [0:3];
    logic               r_sleap [0:3];
    logic               r_sdone [0:3];
    logic               r_szero [0:3];

    // month stage and output stage
    t_year              r_y11;
    logic [8:0]         r_doy11;
    logic               r_leap11;
    logic               r_zero11;
    logic [3:0]         r_idx11;
    t_year              r_o_year;
    t_mon               r_o_mon;
    t_day               r_o_day;

    // combinational next values
    logic [HRS_W-1:0]   n_hours1;
    t_min               n_mn1;
    logic [31:0]        h60;
    logic [31:0]        mdiff;
    logic [DAYS_W-1:0]  n_days3;
    t_hour              n_hr3;
    logic [4:0]         d24;
    t_year              n_y5;
    logic [8:0]         n_r5;
    logic [5:0]         q100;
    logic [2:0]         q1000;
    logic [9:0]         prior_leaps;
    logic [6:0]         r100;
    logic [9:0]         r1000;
    logic [3:0]         n_lk7;
    t_doy               n_doy7;
    t_year              n_sy    [1:3];
    t_doy               n_sdoy  [1:3];
    logic               n_sleap [1:3];
    logic               n_sdone [1:3];
    logic               n_szero [1:3];
    logic [3:0]         n_idx11;
    t_mon               n_o_mon;
    t_day               n_o_day;
    logic [8:0]         dstart;

    // ready chain from the output back to the input
    always_comb begin
        en[NST-1] = !r_vld[NST-1] || i_m_axis_tready;
        for (int k = NST-2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tdata  = {r_mn[NST-1], r_hr[NST-1], r_o_day, r_o_mon, r_o_year};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // minutes and hours split
    always_comb begin
        n_hours1 = r_p0[SH_DIV60 +: HRS_W];
        h60      = {n_hours1, 6'b0} - {4'b0, n_hours1, 2'b0};
        mdiff    = {1'b0, r_t0} - h60;
        n_mn1    = mdiff[MIN_W-1:0];
    end

    // hours into days and hour of day
    always_comb begin
        n_days3 = r_p2[SH_DIV3 +: DAYS_W];
        d24     = {n_days3[0], 4'b0} + {n_days3[1:0], 3'b0};
        n_hr3   = r_hours2[4:0] - d24;
    end

    // first year guess and remainder
    always_comb begin
        n_y5 = r_p4[SH_DIV365 +: YEAR_W];
        n_r5 = r_days4[8:0] - 9'(n_y5) * 9'd365;
    end

    // leap tally and leap flag of the first guess, and leap flags of the three years below
    always_comb begin
        q100        = r_p100[SH_DIV100 +: 6];
        q1000       = r_p1000[SH_DIV1000 +: 3];
        prior_leaps = 10'(r_y6[11:2]) - 10'(q100) + 10'(q1000);
        r100        = r_y6[6:0] - 7'(q100) * 7'd100;
        r1000       = r_y6[9:0] - 10'(q1000) * 10'd1000;
        for (int k = 0; k < 4; k++) begin
            n_lk7[k] = (r_y6[1:0] == 2'(k)) && ((r100 != 7'(k)) || (r1000 == 10'(k)));
        end
        n_doy7 = t_doy'(12'(r_r6) - 12'(prior_leaps) + 12'(n_lk7[0]));
    end

    // year search steps: stop on a positive day of year or the exact boundary
    always_comb begin
        for (int j = 1; j < 4; j++) begin
            n_sy[j]    = r_sy[j-1];
            n_sdoy[j]  = r_sdoy[j-1];
            n_sleap[j] = r_sleap[j-1];
            n_sdone[j] = r_sdone[j-1];
            n_szero[j] = r_szero[j-1];
            if (!r_sdone[j-1]) begin
                if (r_sdoy[j-1] > 12'sd0) begin
                    n_sdone[j] = 1'b1;
                end else if (r_sdoy[j-1] == 12'sd0 && r_hr[6+j] == '0
                             && r_mn[6+j] == '0) begin
                    n_sdone[j] = 1'b1;
                    n_szero[j] = 1'b1;
                end else begin
                    n_sy[j]    = r_sy[j-1] - 12'd1;
                    n_sdoy[j]  = r_sdoy[j-1] + 12'sd365 + t_doy'(12'(r_slk[j-1][j]));
                    n_sleap[j] = r_slk[j-1][j];
                end
            end
        end
    end

    // month scan: first month whose last day is not before the day of year
    always_comb begin
        n_idx11 = 4'd11;
        for (int i = 11; i >= 0; i--) begin
            if (r_sdoy[3][8:0] <= f_cum_end(4'(i), r_sleap[3])) begin
                n_idx11 = 4'(i);
            end
        end
    end

    // day of month and month number
    always_comb begin
        dstart  = f_cum_start(r_idx11, r_leap11);
        n_o_day = 5'(r_doy11 - dstart);
        n_o_mon = r_idx11 + 4'd1;
        if (r_zero11) begin
            n_o_day = '0;
            n_o_mon = '0;
        end
    end

    // pipeline payload registers
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_t0 <= i_s_axis_tdata[TOT_W-1:0];
            r_p0 <= 63'(i_s_axis_tdata[TOT_W-1:0]) * 63'(M_DIV60);
        end
        if (en[1]) begin
            r_hours1 <= n_hours1;
            r_mn[1]  <= n_mn1;
        end
        if (en[2]) begin
            r_p2     <= 47'(r_hours1[HRS_W-1:3]) * 47'(M_DIV3);
            r_hours2 <= r_hours1;
        end
        if (en[3]) begin
            r_days3 <= n_days3;
            r_hr[3] <= n_hr3;
        end
        if (en[4]) begin
            r_p4    <= 43'(r_days3) * 43'(M_DIV365);
            r_days4 <= r_days3;
        end
        if (en[5]) begin
            r_y5 <= n_y5;
            r_r5 <= n_r5;
        end
        if (en[6]) begin
            r_y6    <= r_y5;
            r_r6    <= r_r5;
            r_p100  <= 25'(r_y5) * 25'(M_DIV100);
            r_p1000 <= 26'(r_y5) * 26'(M_DIV1000);
        end
        if (en[7]) begin
            r_sy[0]    <= r_y6;
            r_sdoy[0]  <= n_doy7;
            r_slk[0]   <= n_lk7;
            r_sleap[0] <= n_lk7[0];
            r_sdone[0] <= 1'b0;
            r_szero[0] <= 1'b0;
        end
        for (int j = 1; j < 4; j++) begin
            if (en[7+j]) begin
                r_sy[j]    <= n_sy[j];
                r_sdoy[j]  <= n_sdoy[j];
                r_slk[j]   <= r_slk[j-1];
                r_sleap[j] <= n_sleap[j];
                r_sdone[j] <= n_sdone[j];
                r_szero[j] <= n_szero[j];
            end
        end
        if (en[11]) begin
            r_y11    <= r_sy[3];
            r_doy11  <= r_sdoy[3][8:0];
            r_leap11 <= r_sleap[3];
            r_zero11 <= r_szero[3];
            r_idx11  <= n_idx11;
        end
        if (en[12]) begin
            r_o_year <= r_y11;
            r_o_mon  <= n_o_mon;
            r_o_day  <= n_o_day;
        end
        // minute and hour ride along with their word
        for (int k = 2; k < NST; k++) begin
            if (en[k]) begin
                r_mn[k] <= r_mn[k-1];
            end
        end
        for (int k = 4; k < NST; k++) begin
            if (en[k]) begin
                r_hr[k] <= r_hr[k-1];
            end
        end
    end

    // checks
    `MCD_ASSERT_ALWAYS(a_rst_empties, i_clk, !i_rst_n |=> !o_m_axis_tvalid)
    `MCD_ASSERT(a_search_ends, i_clk, i_rst_n,
                (r_vld[10] && !r_szero[3]) |-> (r_sdoy[3] > 12'sd0))
    `MCD_ASSERT(a_boundary_pair, i_clk, i_rst_n,
                o_m_axis_tvalid |-> ((r_o_mon == '0) == (r_o_day == '0)))
    `MCD_ASSERT(a_time_range, i_clk, i_rst_n,
                o_m_axis_tvalid |-> (r_hr[NST-1] < 5'd24 && r_mn[NST-1] < 6'd60
                                     && r_o_mon <= 4'd12))
    `MCD_ASSERT(a_stall_full, i_clk, i_rst_n, !o_s_axis_tready |-> (&r_vld))

endmodule

// ===== verif/minutes_to_calendar_date_core_test.sv =====
// Self-checking stream testbench for minutes_to_calendar_date_core.
// Depends on mcd_pkg and the core; a scoreboard class predicts each date word.

module minutes_to_calendar_date_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mcd_pkg::*;

    localparam int  LIMIT_CYCLES = 400000;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  HOLD_AT_ITEM = 400;
    localparam int  RANDOM_ITEMS = 750;
    localparam int  DRAIN_CYCLES = 40;
    localparam logic [30:0] MAX_MINUTES = 31'h7FFF_FFFF;

    // expected date of one input word
    typedef struct {
        logic [30:0] minutes;
        t_year       year;
        t_mon        month;
        t_day        day;
        t_hour       hour;
        t_min        minute;
    } t_calendar;

    class calendar_board;
        t_calendar due_dates[$];
        int        mismatches = 0;
        int        checked    = 0;
        int        boundaries = 0;

        static function automatic longint leap_year(input longint y);
            return ((y % 4) == 0 && ((y % 100) != 0 || (y % 1000) == 0)) ? 1 : 0;
        endfunction

        static function automatic longint month_days(input int idx, input longint leap);
            case (idx)
                1:           return 28 + leap;
                3, 5, 8, 10: return 30;
                default:     return 31;
            endcase
        endfunction

        // split a minute count into year, month, day, hour and minute
        static function automatic t_calendar calendar_of(input logic [30:0] m);
            t_calendar c;
            longint    total, hrs_all, mn, hr, days, y, doy, leap, prior;
            int        idx;
            bit        done, boundary, scanning;
            total    = longint'(m);
            mn       = total % 60;
            hrs_all  = total / 60;
            hr       = hrs_all % 24;
            days     = hrs_all / 24;
            y        = days / 365;
            doy      = 0;
            leap     = 0;
            done     = 0;
            boundary = 0;
            // year search: step down until doy > 0, the exact boundary or year 0
            while (!done) begin
                prior = y / 4 - y / 100 + y / 1000;
                leap  = leap_year(y);
                doy   = days - y * 365 - prior + leap;
                if (doy > 0) begin
                    done = 1;
                end else if (doy == 0 && hr == 0 && mn == 0) begin
                    done     = 1;
                    boundary = 1;
                end else if (y <= 0) begin
                    done = 1;
                end else begin
                    y = y - 1;
                end
            end
            c.minutes = m;
            c.year    = t_year'(y);
            c.hour    = t_hour'(hr);
            c.minute  = t_min'(mn);
            if (boundary) begin
                c.month = '0;
                c.day   = '0;
            end else begin
                // month scan, December catches anything past the end
                idx      = 0;
                scanning = 1;
                while (scanning && idx < 12) begin
                    doy = doy - month_days(idx, leap);
                    if (doy <= 0) scanning = 0;
                    else idx++;
                end
                if (idx >= 12) idx = 11;
                c.day   = t_day'(doy + month_days(idx, leap));
                c.month = t_mon'(idx + 1);
            end
            return c;
        endfunction

        function void note_minutes(input logic [30:0] m);
            due_dates.push_back(calendar_of(m));
        endfunction

        function void check_word(input logic [TDATA_W-1:0] w);
            t_calendar e;
            t_year     yr;
            t_mon      mo;
            t_day      dy;
            t_hour     hr;
            t_min      mi;
            yr = w[11:0];
            mo = w[15:12];
            dy = w[20:16];
            hr = w[25:21];
            mi = w[31:26];
            checked++;
            if (due_dates.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", w);
                return;
            end
            e = due_dates.pop_front();
            if (e.month == 0) boundaries++;
            if (yr !== e.year || mo !== e.month || dy !== e.day ||
                hr !== e.hour || mi !== e.minute) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch for %0d min: exp %0d-%0d-%0d %0d:%0d got %0d-%0d-%0d %0d:%0d",
                             e.minutes, e.year, e.month, e.day, e.hour, e.minute,
                             yr, mo, dy, hr, mi);
            end
        endfunction

        function int pending();
            return due_dates.size();
        endfunction
    endclass

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;

    calendar_board sb = new();
    int            n_in       = 0;
    int            cycles     = 0;
    int            burst_left = 0;
    bit            held       = 0;

    minutes_to_calendar_date_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
            $display("minutes_to_calendar_date_core_test: FAIL");
            $finish;
        end
    end

    // watch both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                sb.note_minutes(s_tdata[30:0]);
                n_in++;
            end
            if (m_tvalid && m_tready) sb.check_word(m_tdata);
        end
    end

    // receiver: stall modes in random stretches, one long hold-off
    initial begin
        int mode;
        int span;
        @(posedge i_rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 64);
            repeat (span) begin
                @(negedge i_clk);
                if (!held && n_in >= HOLD_AT_ITEM) begin
                    held = 1;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // offer one word, wait for it to go in, then maybe end the burst
    task automatic offer(input logic [30:0] v);
        int seen;
        int gap;
        s_tdata  <= {1'b0, v};
        s_tvalid <= 1'b1;
        seen = n_in;
        do @(negedge i_clk); while (n_in == seen);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // first day of year y as a day count, as the block counts it
    function automatic longint year_start(input longint y);
        return y * 365 + y / 4 - y / 100 + y / 1000 - calendar_board::leap_year(y);
    endfunction

    function automatic logic [30:0] clip(input longint v);
        if (v < 0) return '0;
        if (v > longint'(MAX_MINUTES)) return MAX_MINUTES;
        return v[30:0];
    endfunction

    // a minute count close to a year boundary
    function automatic logic [30:0] near_year();
        longint y, d;
        y = longint'($urandom_range(1, 4080));
        d = year_start(y) * 1440;
        case ($urandom_range(0, 3))
            0:       return clip(d);
            1:       return clip(d - 1);
            2:       return clip(d + longint'($urandom_range(1, 3 * 1440)));
            default: return clip(d - longint'($urandom_range(1, 3 * 1440)));
        endcase
    endfunction

    // a minute count on or beside the last day of a month
    function automatic logic [30:0] near_month_end();
        longint y, doy, leap;
        int     mon;
        y    = longint'($urandom_range(0, 4080));
        leap = calendar_board::leap_year(y);
        mon  = $urandom_range(0, 11);
        doy  = 0;
        for (int k = 0; k <= mon; k++) doy += calendar_board::month_days(k, leap);
        doy = doy + longint'($urandom_range(0, 2)) - 1;
        return clip((year_start(y) + doy) * 1440 + longint'($urandom_range(0, 1439)));
    endfunction

    initial begin
        longint      directed[$];
        logic [30:0] v;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, year boundaries, leap rules, Feb 29
        directed = '{0, 1, 59, 60, 1439, 1440, 525599, 525600, 525601,
                     year_start(4) * 1440, year_start(4) * 1440 - 1,
                     (year_start(4) + 60) * 1440 + 720,
                     year_start(100) * 1440, (year_start(100) + 60) * 1440,
                     year_start(1000) * 1440, (year_start(1000) + 60) * 1440 + 1,
                     year_start(1900) * 1440 + 59, year_start(2000) * 1440,
                     (year_start(2000) + 366) * 1440 - 1, year_start(4000) * 1440,
                     longint'(31'h2AAA_AAAA), longint'(31'h5555_5555),
                     longint'(MAX_MINUTES) - 1, longint'(MAX_MINUTES)};
        foreach (directed[k]) offer(clip(directed[k]));

        // random mix: wide values, year and month boundaries, small counts, values near the maximum, whole days
        repeat (RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: v = 31'($urandom());
                8, 9, 10, 11, 12:       v = near_year();
                13, 14, 15, 16:         v = near_month_end();
                17:                     v = 31'($urandom_range(0, 2 * 525600));
                18:                     v = MAX_MINUTES - 31'($urandom_range(0, 5000));
                default:                v = 31'($urandom_range(0, 1440) * 1440);
            endcase
            offer(v);
        end
        s_tvalid <= 1'b0;

        // drain, then keep watching for any stray word
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d minute counts, checked %0d date words (%0d on an exact year start)",
                 n_in, sb.checked, sb.boundaries);
        $display("mismatches %0d, outstanding %0d, long receiver hold-off %s",
                 sb.mismatches, sb.pending(), held ? "done" : "missed");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("minutes_to_calendar_date_core_test: PASS");
        end else begin
            $display("minutes_to_calendar_date_core_test: FAIL");
        end
        $finish;
    end

endmodule
